// ----- hw/rtl/ope_pkg.sv -----
package ope_pkg;

  localparam int ExponentBitsDef = 16;
  localparam int ChunkBits       = 16;
  localparam int LenBits         = 5;
  localparam int MaxChunks       = 3;

  typedef enum logic {
    ACT_HEADER = 1'b0,
    ACT_DIGIT  = 1'b1
  } ope_action_t;

  typedef struct packed {
    logic        action;
    logic        negative;
    logic        is_zero;
    logic        exponent_negative;
    logic [15:0] exponent_magnitude;
    logic [3:0]  digit;
    logic        last_digit;
  } ope_in_t;

  typedef struct packed {
    logic [ChunkBits-1:0] chunk_bits;
    logic [LenBits-1:0]   chunk_length;
    logic                 last;
  } ope_out_t;

  typedef struct packed {
    ope_out_t [MaxChunks-1:0] chunk;
    logic [1:0]               cnt;
  } ope_bundle_t;

endpackage

// ----- hw/rtl/ope_encoder.sv -----
module ope_encoder #(
  parameter int EXPONENT_BITS = ope_pkg::ExponentBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ope_pkg::ope_in_t    in_word,
  input  logic                fire,
  output ope_pkg::ope_bundle_t bundle
);
  import ope_pkg::*;

  localparam logic [15:0] OffLimit = (EXPONENT_BITS >= 16) ? 16'hFFFF :
                                     16'((64'd1 << EXPONENT_BITS) - 64'd1);

  logic       neg_r, neg_nxt;
  logic       await_r, await_nxt;
  logic [1:0] grp_cnt_r, grp_cnt_nxt;
  logic [9:0] grp_val_r, grp_val_nxt;

  logic [16:0] off_raw;
  logic [15:0] off;
  logic [4:0]  le;
  logic [16:0] mask17;
  logic [15:0] mask;
  logic [15:0] top;
  logic [15:0] prefix;
  logic [15:0] rem;
  logic [3:0]  d9;
  logic [3:0]  first_val;
  logic [9:0]  term;
  logic [9:0]  sum;
  logic [9:0]  declet;
  logic        flush;

  always_comb begin
    off_raw = {1'b0, in_word.exponent_magnitude} + 17'd2;
    off     = (off_raw > {1'b0, OffLimit}) ? OffLimit : off_raw[15:0];
    le      = '0;
    for (int i = 0; i < 16; i++) begin
      if (off[i]) begin
        le = 5'(i + 1);
      end
    end
    mask17 = (17'd1 << le) - 17'd1;
    mask   = mask17[15:0];
    top    = 16'((17'd1 << le) >> 1);
    prefix = mask - 16'd1;
    rem    = off - top;
    if (in_word.negative != in_word.exponent_negative) begin
      prefix = prefix ^ mask;
      rem    = rem ^ (mask >> 1);
    end
  end

  always_comb begin
    d9        = (in_word.digit > 4'd9) ? 4'd9 : in_word.digit;
    first_val = neg_r ? (4'd10 - d9) : d9;
    unique case (grp_cnt_r)
      2'd0: term = 10'(d9) * 10'd100;
      2'd1: term = 10'(d9) * 10'd10;
      2'd2: term = 10'(d9);
      2'd3: term = '0;
    endcase
    sum    = grp_val_r + term;
    declet = neg_r ? (10'd999 - sum) : sum;
    flush  = (grp_cnt_r == 2'd2) || in_word.last_digit;
  end

  always_comb begin
    neg_nxt     = neg_r;
    await_nxt   = await_r;
    grp_cnt_nxt = grp_cnt_r;
    grp_val_nxt = grp_val_r;
    bundle      = '0;
    unique case (ope_action_t'(in_word.action))
      ACT_HEADER: begin
        grp_cnt_nxt = '0;
        grp_val_nxt = '0;
        if (in_word.is_zero) begin
          neg_nxt   = 1'b0;
          await_nxt = 1'b0;
          bundle.chunk[0] = '{chunk_bits: 16'd2, chunk_length: 5'd2, last: 1'b1};
          bundle.cnt      = 2'd1;
        end else begin
          neg_nxt   = in_word.negative;
          await_nxt = 1'b1;
          bundle.chunk[0] = '{chunk_bits: in_word.negative ? 16'd0 : 16'd2,
                              chunk_length: 5'd2, last: 1'b0};
          bundle.chunk[1] = '{chunk_bits: prefix, chunk_length: le, last: 1'b0};
          bundle.chunk[2] = '{chunk_bits: rem, chunk_length: le - 5'd1, last: 1'b0};
          bundle.cnt      = 2'd3;
        end
      end
      ACT_DIGIT: begin
        if (await_r) begin
          await_nxt   = 1'b0;
          grp_cnt_nxt = '0;
          grp_val_nxt = '0;
          bundle.chunk[0] = '{chunk_bits: 16'(first_val), chunk_length: 5'd4,
                              last: in_word.last_digit};
          bundle.cnt      = 2'd1;
        end else if (flush) begin
          grp_cnt_nxt = '0;
          grp_val_nxt = '0;
          bundle.chunk[0] = '{chunk_bits: 16'(declet), chunk_length: 5'd10,
                              last: in_word.last_digit};
          bundle.cnt      = 2'd1;
        end else begin
          grp_cnt_nxt = grp_cnt_r + 2'd1;
          grp_val_nxt = sum;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r     <= 1'b0;
      await_r   <= 1'b0;
      grp_cnt_r <= '0;
      grp_val_r <= '0;
    end else if (fire) begin
      neg_r     <= neg_nxt;
      await_r   <= await_nxt;
      grp_cnt_r <= grp_cnt_nxt;
      grp_val_r <= grp_val_nxt;
    end
  end

endmodule

// ----- hw/rtl/ope_serializer.sv -----
module ope_serializer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ope_pkg::ope_bundle_t bundle,
  input  logic                 load,
  output logic                 load_ok,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ope_pkg::ope_out_t    out_word
);
  import ope_pkg::*;

  ope_out_t [MaxChunks-1:0] chunk_r;
  logic [1:0] cnt_r;
  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic       at_last;
  logic       take;

  assign at_last   = (idx_r == (cnt_r - 2'd1));
  assign take      = vld_r && !out_stall;
  assign load_ok   = !vld_r || (take && at_last);
  assign out_valid = vld_r;
  assign out_word  = chunk_r[idx_r];

  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    priority if (load) begin
      vld_nxt = (bundle.cnt != 2'd0);
      idx_nxt = '0;
    end else if (take && at_last) begin
      vld_nxt = 1'b0;
    end else if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chunk_r <= bundle.chunk;
      cnt_r   <= bundle.cnt;
    end
  end

endmodule

// ----- hw/rtl/order_preserving_decimal_encoder.sv -----
// Channel  Direction  Word type    Handshake
// in_      input      ope_in_t     in_valid / in_stall
// out_     output     ope_out_t    out_valid / out_stall
//
// An item passes an input register and then a chunk register on its way to the first chunk.
// A digit item yields at most one chunk; a nonzero header yields three chunks that leave
// the chunk register one at a time, so the output port sets the rate of headers.
// Digits that leave a declet unfinished give no chunk and free the register at once.
// Reset clears the valid flags, the sign, the first-digit flag and the declet state.
// A stall on the output holds the chunk register, then the input register, then in_stall.
module order_preserving_decimal_encoder #(
  parameter int EXPONENT_BITS = ope_pkg::ExponentBitsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ope_pkg::ope_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output ope_pkg::ope_out_t out_word
);
  import ope_pkg::*;

  logic        in_vld_r, in_vld_nxt;
  ope_in_t     in_word_r;
  logic        move;
  logic        load_ok;
  ope_bundle_t bundle;

  assign move       = in_vld_r && load_ok;
  assign in_stall   = in_vld_r && !load_ok;
  assign in_vld_nxt = in_stall ? in_vld_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_word_r <= '0;
    end else if (in_valid && !in_stall) begin
      in_word_r <= in_word;
    end
  end

  ope_encoder #(
    .EXPONENT_BITS (EXPONENT_BITS)
  ) u_encoder (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word_r),
    .fire    (move),
    .bundle  (bundle)
  );

  ope_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .bundle    (bundle),
    .load      (move),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
